// ----- rtl/eu2r_pkg.sv -----
// Shared constants, types and arithmetic helpers for the Euler-angle to rotation-matrix block.
package eu2r_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 14;
  localparam int FIELD_W      = 16;
  localparam int NUM_ANGLES   = 3;
  localparam int NUM_ENTRIES  = 9;
  localparam int TURN_W       = 32;
  localparam int CORDIC_STEPS = 31;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CW           = 34;
  localparam int ZW           = TURN_W + 1;
  localparam int PROD_W       = 2 * FIELD_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_RS    = CORDIC_FRAC - FRAC_BITS;
  localparam int MATRIX_LAT   = 5;

  localparam int PITCH = 0;
  localparam int YAW   = 1;
  localparam int ROLL  = 2;

  typedef logic signed [CW-1:0]      cw_t;
  typedef logic signed [ZW-1:0]      zw_t;
  typedef logic signed [FIELD_W-1:0] q_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // One angle's rotation state as it moves along the CORDIC row.
  typedef struct packed {
    cw_t  x;
    cw_t  y;
    zw_t  z;
    logic neg;
  } lane_t;

  typedef lane_t [NUM_ANGLES-1:0] trio_t;

  localparam cw_t GAIN_INV = CW'(64'd652032874);
  localparam zw_t Q_TURN   = ZW'(64'd1 << (TURN_W - 2));
  localparam zw_t H_TURN   = ZW'(64'd1 << (TURN_W - 1));
  localparam q_t  ONE      = q_t'(1) <<< FRAC_BITS;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic zw_t atan_turn(input logic [STEP_W-1:0] i);
    logic [30:0] v;
    unique case (i)
      5'd0:    v = 31'd536870912;
      5'd1:    v = 31'd316933406;
      5'd2:    v = 31'd167458907;
      5'd3:    v = 31'd85004756;
      5'd4:    v = 31'd42667331;
      5'd5:    v = 31'd21354465;
      5'd6:    v = 31'd10679838;
      5'd7:    v = 31'd5340245;
      5'd8:    v = 31'd2670163;
      5'd9:    v = 31'd1335087;
      5'd10:   v = 31'd667544;
      5'd11:   v = 31'd333772;
      5'd12:   v = 31'd166886;
      5'd13:   v = 31'd83443;
      5'd14:   v = 31'd41722;
      5'd15:   v = 31'd20861;
      5'd16:   v = 31'd10430;
      5'd17:   v = 31'd5215;
      5'd18:   v = 31'd2608;
      5'd19:   v = 31'd1304;
      5'd20:   v = 31'd652;
      5'd21:   v = 31'd326;
      5'd22:   v = 31'd163;
      5'd23:   v = 31'd81;
      5'd24:   v = 31'd41;
      5'd25:   v = 31'd20;
      5'd26:   v = 31'd10;
      5'd27:   v = 31'd5;
      5'd28:   v = 31'd3;
      5'd29:   v = 31'd1;
      5'd30:   v = 31'd1;
      default: v = 31'd0;
    endcase
    return zw_t'({2'b00, v});
  endfunction

  // Widens a binary angle to a turn fraction and folds it into +-90 degrees.
  function automatic lane_t prep_lane(input logic [FIELD_W-1:0] ang);
    logic [TURN_W-1:0] a;
    zw_t               z;
    lane_t             l;
    a = TURN_W'(ang) << (TURN_W - ANGLE_BITS);
    z = zw_t'({a[TURN_W-1], a});
    l.neg = 1'b0;
    if (z > Q_TURN) begin
      z     = z - H_TURN;
      l.neg = 1'b1;
    end else if (z < -Q_TURN) begin
      z     = z + H_TURN;
      l.neg = 1'b1;
    end
    l.x = GAIN_INV;
    l.y = '0;
    l.z = z;
    return l;
  endfunction

  function automatic q_t clamp_one(input sum_t t);
    q_t r;
    if (t > sum_t'(ONE)) begin
      r = ONE;
    end else if (t < -sum_t'(ONE)) begin
      r = -ONE;
    end else begin
      r = q_t'(t);
    end
    return r;
  endfunction

  // Rounds a CORDIC output from Q30 to FRAC_BITS and saturates.
  function automatic q_t round_cordic(input cw_t v);
    localparam cw_t HALF = (CORDIC_RS > 0) ? (cw_t'(1) <<< (CORDIC_RS - 1)) : '0;
    cw_t t;
    t = (v + HALF) >>> CORDIC_RS;
    return clamp_one(sum_t'(t));
  endfunction

  // Rounds a product or sum held at twice FRAC_BITS and saturates.
  function automatic q_t round_prod(input sum_t v);
    localparam sum_t HALF = sum_t'(1) <<< (FRAC_BITS - 1);
    sum_t t;
    t = (v + HALF) >>> FRAC_BITS;
    return clamp_one(t);
  endfunction

endpackage

// ----- rtl/eu2r_cordic_cell.sv -----
// One CORDIC rotation cell, applied to the pitch, yaw and roll lanes side by side.
module eu2r_cordic_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [eu2r_pkg::STEP_W-1:0]  step_i,
  input  logic                         valid_i,
  input  eu2r_pkg::trio_t              lanes_i,
  output logic                         valid_o,
  output eu2r_pkg::trio_t              lanes_o
);
  import eu2r_pkg::*;

  logic  valid_q;
  trio_t lanes_d, lanes_q;
  zw_t   atan;

  assign atan = atan_turn(step_i);

  always_comb begin
    cw_t dx;
    cw_t dy;
    lanes_d = lanes_i;
    for (int k = 0; k < NUM_ANGLES; k++) begin
      dx = lanes_i[k].y >>> step_i;
      dy = lanes_i[k].x >>> step_i;
      if (!lanes_i[k].z[ZW-1]) begin
        lanes_d[k].x = lanes_i[k].x - dx;
        lanes_d[k].y = lanes_i[k].y + dy;
        lanes_d[k].z = lanes_i[k].z - atan;
      end else begin
        lanes_d[k].x = lanes_i[k].x + dx;
        lanes_d[k].y = lanes_i[k].y - dy;
        lanes_d[k].z = lanes_i[k].z + atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;

endmodule

// ----- rtl/eu2r_matrix.sv -----
// Rounding of the sines and cosines and the pipelined products that form the nine entries.
module eu2r_matrix (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            en_i,
  input  logic                                            valid_i,
  input  eu2r_pkg::trio_t                                 lanes_i,
  output logic                                            valid_o,
  output eu2r_pkg::q_t [eu2r_pkg::NUM_ENTRIES-1:0]        entries_o
);
  import eu2r_pkg::*;

  logic [MATRIX_LAT-1:0] valid_q;

  // Sines and cosines after sign correction and rounding.
  q_t [NUM_ANGLES-1:0] sn_d, cs_d, sn_q, cs_q;

  // First products.
  prod_t cpcy_q, cpsy_q, srcp_q, crcp_q, srsp_q, crsp_q;
  prod_t crsy1_q, crcy1_q, srsy1_q, srcy1_q;
  q_t    sp1_q, sy1_q, cy1_q;

  // Rounded two-factor entries and the leading pairs of the three-factor terms.
  q_t    x0_q, x1_q, x2_q, y2_q, z2_q, srspr_q, crspr_q, sy2_q, cy2_q;
  prod_t crsy2_q, crcy2_q, srsy2_q, srcy2_q;

  // Second products.
  prod_t a_q, b_q, c_q, d_q;
  prod_t crsy3_q, crcy3_q, srsy3_q, srcy3_q;
  q_t    x0b_q, x1b_q, x2b_q, y2b_q, z2b_q;

  q_t [NUM_ENTRIES-1:0] ent_q;

  always_comb begin
    cw_t xs;
    cw_t ys;
    for (int k = 0; k < NUM_ANGLES; k++) begin
      xs      = lanes_i[k].neg ? -lanes_i[k].x : lanes_i[k].x;
      ys      = lanes_i[k].neg ? -lanes_i[k].y : lanes_i[k].y;
      cs_d[k] = round_cordic(xs);
      sn_d[k] = round_cordic(ys);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[MATRIX_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sn_q <= sn_d;
      cs_q <= cs_d;

      cpcy_q  <= cs_q[PITCH] * cs_q[YAW];
      cpsy_q  <= cs_q[PITCH] * sn_q[YAW];
      srcp_q  <= sn_q[ROLL]  * cs_q[PITCH];
      crcp_q  <= cs_q[ROLL]  * cs_q[PITCH];
      srsp_q  <= sn_q[ROLL]  * sn_q[PITCH];
      crsp_q  <= cs_q[ROLL]  * sn_q[PITCH];
      crsy1_q <= cs_q[ROLL]  * sn_q[YAW];
      crcy1_q <= cs_q[ROLL]  * cs_q[YAW];
      srsy1_q <= sn_q[ROLL]  * sn_q[YAW];
      srcy1_q <= sn_q[ROLL]  * cs_q[YAW];
      sp1_q   <= sn_q[PITCH];
      sy1_q   <= sn_q[YAW];
      cy1_q   <= cs_q[YAW];

      x0_q    <= round_prod(sum_t'(cpcy_q));
      x1_q    <= round_prod(sum_t'(cpsy_q));
      x2_q    <= -sp1_q;
      y2_q    <= round_prod(sum_t'(srcp_q));
      z2_q    <= round_prod(sum_t'(crcp_q));
      srspr_q <= round_prod(sum_t'(srsp_q));
      crspr_q <= round_prod(sum_t'(crsp_q));
      sy2_q   <= sy1_q;
      cy2_q   <= cy1_q;
      crsy2_q <= crsy1_q;
      crcy2_q <= crcy1_q;
      srsy2_q <= srsy1_q;
      srcy2_q <= srcy1_q;

      a_q     <= srspr_q * cy2_q;
      b_q     <= srspr_q * sy2_q;
      c_q     <= crspr_q * cy2_q;
      d_q     <= crspr_q * sy2_q;
      crsy3_q <= crsy2_q;
      crcy3_q <= crcy2_q;
      srsy3_q <= srsy2_q;
      srcy3_q <= srcy2_q;
      x0b_q   <= x0_q;
      x1b_q   <= x1_q;
      x2b_q   <= x2_q;
      y2b_q   <= y2_q;
      z2b_q   <= z2_q;

      ent_q[0] <= x0b_q;
      ent_q[1] <= x1b_q;
      ent_q[2] <= x2b_q;
      ent_q[3] <= round_prod(sum_t'(a_q) - sum_t'(crsy3_q));
      ent_q[4] <= round_prod(sum_t'(b_q) + sum_t'(crcy3_q));
      ent_q[5] <= y2b_q;
      ent_q[6] <= round_prod(sum_t'(c_q) + sum_t'(srsy3_q));
      ent_q[7] <= round_prod(sum_t'(d_q) - sum_t'(srcy3_q));
      ent_q[8] <= z2b_q;
    end
  end

  assign valid_o   = valid_q[MATRIX_LAT-1];
  assign entries_o = ent_q;

endmodule

// ----- rtl/euler_to_rotation_matrix.sv -----
// Top level of the Euler-angle (pitch, yaw, roll) to 3x3 rotation-matrix block.
//
// The block takes one word of three binary angles (pitch, yaw, roll; 65536 is one full
// turn, so every angle wraps by itself) and returns one word holding the nine entries of
// the rotation matrix, column by column, as signed Q1.14 values saturated to plus or
// minus one. Column X is the forward vector, column Z the up vector, and column Y is
// the right vector negated. It accepts a new word in every cycle while no word waits at
// the output, and keeps no state between words. On its way to the output register each
// word passes a row of CORDIC cells, one per rotation step, that turn all three angles
// side by side, then registers for rounding, the first products, rounding of the leading
// pairs, the second products, and the sums that land in the output register. The whole
// pipeline advances together whenever the output register is empty or being read, so
// the input side is ready exactly then; a word waiting at the output stalls the row.
module euler_to_rotation_matrix (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0 up: pitch_angle[15:0], yaw_angle[31:16], roll_angle[47:32].
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0 up, 16 bits each: col_x_0, col_x_1, col_x_2, col_y_0, col_y_1,
  // col_y_2, col_z_0, col_z_1, col_z_2.
  output logic [143:0] m_axis_tdata
);
  import eu2r_pkg::*;

  // Pipeline advance: every stage moves on when the output word is gone or leaving.
  logic en;

  // Hand-over points between neighbouring cells; entry 0 is the input of the first cell.
  logic  [CORDIC_STEPS:0] cell_valid;
  trio_t [CORDIC_STEPS:0] cell_lanes;

  q_t [NUM_ENTRIES-1:0] entries;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // The angles are widened to turn fractions and folded into +-90 degrees on the way in.
  assign cell_valid[0]       = s_axis_tvalid;
  assign cell_lanes[0][PITCH] = prep_lane(s_axis_tdata[FIELD_W*PITCH +: FIELD_W]);
  assign cell_lanes[0][YAW]   = prep_lane(s_axis_tdata[FIELD_W*YAW   +: FIELD_W]);
  assign cell_lanes[0][ROLL]  = prep_lane(s_axis_tdata[FIELD_W*ROLL  +: FIELD_W]);

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    eu2r_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(g)),
      .valid_i (cell_valid[g]),
      .lanes_i (cell_lanes[g]),
      .valid_o (cell_valid[g+1]),
      .lanes_o (cell_lanes[g+1])
    );
  end

  eu2r_matrix u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (cell_valid[CORDIC_STEPS]),
    .lanes_i   (cell_lanes[CORDIC_STEPS]),
    .valid_o   (m_axis_tvalid),
    .entries_o (entries)
  );

  assign m_axis_tdata = entries;

`ifndef SYNTHESIS
  // An accepted word must occupy the first cell on the next edge.
  a_accept_enters_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> cell_valid[1])
    else $error("accepted word did not enter the first CORDIC cell");

  // The input side may only be held off by a word waiting at the output.
  a_stall_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting output word");

  // Saturation keeps the diagonal entries of the matrix within plus or minus one.
  a_entries_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((entries[0] <= ONE) && (entries[0] >= -ONE) &&
                       (entries[4] <= ONE) && (entries[4] >= -ONE) &&
                       (entries[8] <= ONE) && (entries[8] >= -ONE)))
    else $error("matrix entry beyond saturation limit");
`endif

endmodule
